### sv/ckx_pkg.sv
// ----------------------------------------------------------------------------
// ckx_pkg
// Shared widths, character codes, item types and base coding for the
// canonical k-mer extractor.
// ----------------------------------------------------------------------------
package ckx_pkg;

    // field widths
    localparam int NUC_W    = 8;
    localparam int SEQ_ID_W = 32;
    localparam int KMER_W   = 64;
    localparam int K_W      = 6;

    // stream payload widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 96;

    // k-mer length defaults
    localparam int             MAX_KMER_LENGTH_DEF = 32;
    localparam logic [K_W-1:0] KMER_LENGTH_RESET   = 6'd18;

    // recognized sequence characters
    localparam logic [NUC_W-1:0] CHAR_UA = 8'h41;
    localparam logic [NUC_W-1:0] CHAR_UC = 8'h43;
    localparam logic [NUC_W-1:0] CHAR_UG = 8'h47;
    localparam logic [NUC_W-1:0] CHAR_UT = 8'h54;
    localparam logic [NUC_W-1:0] CHAR_LA = 8'h61;
    localparam logic [NUC_W-1:0] CHAR_LC = 8'h63;
    localparam logic [NUC_W-1:0] CHAR_LG = 8'h67;
    localparam logic [NUC_W-1:0] CHAR_LT = 8'h74;

    // 2-bit base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // complement of a base code is its bitwise inverse
    localparam logic [1:0] COMP_XOR = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [1:0]          code;
    } base_t;

    typedef struct packed {
        logic [SEQ_ID_W-1:0] sequence_id;
        logic                last_of_sequence;
        logic [NUC_W-1:0]    nucleotide;
    } in_item_t;

    typedef struct packed {
        logic [SEQ_ID_W-1:0] kmer_sequence_id;
        logic [KMER_W-1:0]   canonical_kmer;
    } out_item_t;

    // decode a character into a 2-bit base, either case
    function automatic base_t decode_base(input logic [NUC_W-1:0] ch);
        base_t b;
        b.valid = 1'b1;
        b.code  = BASE_A;
        case (ch)
            CHAR_UA, CHAR_LA: b.code = BASE_A;
            CHAR_UC, CHAR_LC: b.code = BASE_C;
            CHAR_UG, CHAR_LG: b.code = BASE_G;
            CHAR_UT, CHAR_LT: b.code = BASE_T;
            default:          b.valid = 1'b0;
        endcase
        return b;
    endfunction

endpackage

### sv/canonical_kmer_extractor_unit.sv
// ----------------------------------------------------------------------------
// canonical_kmer_extractor_unit
// Streams DNA characters in and canonical 2-bit k-mers with their read id
// out; k is set through a separate configuration write channel.
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_*       in         tdata {sequence_id, nucleotide}, tlast last_of_sequence
// m_*       out        tdata {kmer_sequence_id, canonical_kmer}
// cfg_*     in         cfg_data kmer_length, always ready
//
// one character per cycle while no k-mer waits on m_*; a k-mer passes the input
// register, then the result register, before it is valid on m_*
// the character-to-character loop runs through the rolling words and run counter,
// so throughput is one item per clock while no k-mer waits on m_*
// reset clears the words, the run counter and both stage valids; k returns to 18
// a stalled result holds the result register; the input register still takes
// characters that produce no k-mer
// ----------------------------------------------------------------------------
module canonical_kmer_extractor_unit
    import ckx_pkg::*;
#(
    parameter int MAX_KMER_LENGTH = MAX_KMER_LENGTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] nucleotide, [39:8] sequence_id
    input  logic                  s_tlast,
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [63:0] canonical_kmer, [95:64] kmer_sequence_id
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [K_W-1:0]        cfg_data
);

    logic [K_W-1:0] kmer_length_reg;
    in_item_t       s_item;
    in_item_t       item;
    logic           item_valid;
    logic           item_take;
    logic           emit;
    logic           out_free;
    out_item_t      result;
    out_item_t      m_item;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KMER_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            kmer_length_reg <= cfg_data;
        end
    end

    // input unpacking
    assign s_item.nucleotide       = s_tdata[NUC_W-1:0];
    assign s_item.sequence_id      = s_tdata[NUC_W +: SEQ_ID_W];
    assign s_item.last_of_sequence = s_tlast;

    ckx_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ckx_kmer_core #(
        .MAX_KMER_LENGTH (MAX_KMER_LENGTH)
    ) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .kmer_length (kmer_length_reg),
        .item_valid  (item_valid),
        .item        (item),
        .out_free    (out_free),
        .item_take   (item_take),
        .emit        (emit),
        .result      (result)
    );

    ckx_output_stage u_output
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (item_take && emit),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_item   (m_item)
    );

    // output packing
    assign m_tdata = {m_item.kmer_sequence_id, m_item.canonical_kmer};

endmodule

### sv/ckx_input_stage.sv
// ----------------------------------------------------------------------------
// ckx_input_stage
// Input register for sequence characters; refills in the same cycle that
// the held character is consumed.
// ----------------------------------------------------------------------------
module ckx_input_stage
    import ckx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t s_item,
    output logic     item_valid,
    output in_item_t item,
    input  logic     item_take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // free when empty or when the held character leaves this cycle
    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture on each input transfer
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

### sv/ckx_kmer_core.sv
// ----------------------------------------------------------------------------
// ckx_kmer_core
// Rolling forward and reverse-complement words, run counter and the
// canonical (smaller) k-mer selection for one character per cycle unless a k-mer waits on the output.
// ----------------------------------------------------------------------------
module ckx_kmer_core
    import ckx_pkg::*;
#(
    parameter int MAX_KMER_LENGTH = MAX_KMER_LENGTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [K_W-1:0] kmer_length,
    input  logic           item_valid,
    input  in_item_t       item,
    input  logic           out_free,
    output logic           item_take,
    output logic           emit,
    output out_item_t      result
);

    localparam int WORD_W = 2 * MAX_KMER_LENGTH;

    logic [WORD_W-1:0] fwd_reg;
    logic [WORD_W-1:0] fwd_next;
    logic [WORD_W-1:0] rev_reg;
    logic [WORD_W-1:0] rev_next;
    logic [K_W-1:0]    run_reg;
    logic [K_W-1:0]    run_next;

    base_t             base;
    logic [K_W-1:0]    k_eff;
    logic [K_W-1:0]    k_m1;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] fwd_shift;
    logic [WORD_W-1:0] rev_down;
    logic [WORD_W-1:0] rev_shift;
    logic [K_W-1:0]    run_inc;
    logic [WORD_W-1:0] kmer_min;
    logic [1:0]        comp;

    assign base = decode_base(item.nucleotide);
    assign comp = base.code ^ COMP_XOR;

    // clamp length into 1..MAX_KMER_LENGTH
    always_comb
    begin
        if (kmer_length == '0)
        begin
            k_eff = K_W'(1);
        end
        else if (kmer_length > K_W'(MAX_KMER_LENGTH))
        begin
            k_eff = K_W'(MAX_KMER_LENGTH);
        end
        else
        begin
            k_eff = kmer_length;
        end
    end

    assign k_m1     = k_eff - K_W'(1);
    assign rev_down = rev_reg >> 2;

    // per-base lanes: mask, and reverse word shifted down with the complement
    // merged into lane k-1 (the lane just above a shortened k folds in there too)
    always_comb
    begin
        for (int j = 0; j < MAX_KMER_LENGTH; j++)
        begin
            mask[2*j +: 2]      = (K_W'(j) < k_eff) ? 2'b11 : 2'b00;
            rev_shift[2*j +: 2] = ((K_W'(j) <= k_m1) ? rev_down[2*j +: 2] : 2'b00)
                                | ((K_W'(j) == k_m1) ? comp : 2'b00);
        end
    end

    assign fwd_shift = {fwd_reg[WORD_W-3:0], base.code} & mask;

    // run counter saturates at k
    assign run_inc  = (run_reg < k_eff) ? run_reg + K_W'(1) : run_reg;
    assign kmer_min = (fwd_shift < rev_shift) ? fwd_shift : rev_shift;

    // result and consume decision
    assign emit      = item_valid && base.valid && (run_inc >= k_eff);
    assign item_take = item_valid && (!emit || out_free);

    assign result.canonical_kmer   = KMER_W'(kmer_min);
    assign result.kmer_sequence_id = item.sequence_id;

    // next state
    always_comb
    begin
        fwd_next = fwd_reg;
        rev_next = rev_reg;
        run_next = run_reg;
        if (item_take)
        begin
            if (item.last_of_sequence)
            begin
                fwd_next = '0;
                rev_next = '0;
                run_next = '0;
            end
            else if (base.valid)
            begin
                fwd_next = fwd_shift;
                rev_next = rev_shift;
                run_next = run_inc;
            end
            else
            begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
            rev_reg <= '0;
            run_reg <= '0;
        end
        else
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
            run_reg <= run_next;
        end
    end

endmodule

### sv/ckx_output_stage.sv
// ----------------------------------------------------------------------------
// ckx_output_stage
// Result register for canonical k-mers; takes a new result in the cycle
// the held one transfers.
// ----------------------------------------------------------------------------
module ckx_output_stage
    import ckx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t result,
    output logic      out_free,
    output logic      m_tvalid,
    input  logic      m_tready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_item   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the canonical k-mer extractor. Characters are fed
// through the input stream, a rolling forward / reverse-complement tracker
// predicts every canonical k-mer, and the output stream is checked in order.
// k is rewritten between quiet phases, including the out-of-range values.
// ----------------------------------------------------------------------------
module tb_top;
    import ckx_pkg::*;

    localparam int MAX_K         = MAX_KMER_LENGTH_DEF;
    localparam int SETTLE_CYCLES = 8;      // pipeline is two deep, leave margin
    localparam int CALM_TAIL     = 150;    // last characters go without idling
    localparam int PHASES        = 12;
    localparam int PHASE_CHARS   = 160;

    typedef enum logic [1:0] {
        STEP_CHAR,
        STEP_SET_K,
        STEP_QUIESCE
    } step_kind_e;

    typedef struct packed {
        step_kind_e          kind;
        logic [NUC_W-1:0]    nuc;
        logic                last;
        logic [SEQ_ID_W-1:0] sid;
        logic [K_W-1:0]      kval;
    } feed_step_t;

    // clock, reset and dut ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [7:0] nucleotide, [39:8] sequence_id
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [63:0] canonical_kmer, [95:64] kmer_sequence_id
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [K_W-1:0]        cfg_data  = '0;

    // stimulus and expected k-mers
    feed_step_t  feed_q[$];
    out_item_t   pending_kmers[$];
    logic [7:0]  base_chars [8];

    // tracker state
    logic [K_W-1:0]    kmer_len = KMER_LENGTH_RESET;
    logic [KMER_W-1:0] fwd_word = '0;
    logic [KMER_W-1:0] rc_word  = '0;
    int                run_len  = 0;

    // bookkeeping
    int chars_queued   = 0;
    int chars_accepted = 0;
    int k_writes       = 0;
    int kmers_checked  = 0;
    int errors         = 0;
    int settle         = 0;
    bit calm           = 1'b0;

    canonical_kmer_extractor_unit #(
        .MAX_KMER_LENGTH (MAX_K)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // roll one accepted character into the tracker, queue the k-mer it completes
    task automatic roll_kmer(input logic [NUC_W-1:0] ch, input logic last,
                             input logic [SEQ_ID_W-1:0] sid);
        logic [1:0]        code;
        bit                is_base;
        int                keff;
        logic [KMER_W-1:0] mask;
        logic [KMER_W-1:0] comp;
        out_item_t         hit;
        is_base = 1'b1;
        code    = BASE_A;
        case (ch)
            CHAR_UA, CHAR_LA: code = BASE_A;
            CHAR_UC, CHAR_LC: code = BASE_C;
            CHAR_UG, CHAR_LG: code = BASE_G;
            CHAR_UT, CHAR_LT: code = BASE_T;
            default:          is_base = 1'b0;
        endcase
        // k of zero behaves as one, anything above the maximum is clamped
        keff = (kmer_len == 0) ? 1 : (kmer_len > MAX_K) ? MAX_K : int'(kmer_len);
        mask = (2 * keff >= KMER_W) ? '1 : ((64'd1 << (2 * keff)) - 64'd1);
        if (!is_base)
        begin
            run_len = 0;
        end
        else
        begin
            comp     = {62'd0, code ^ COMP_XOR};
            fwd_word = ((fwd_word << 2) | {62'd0, code}) & mask;
            rc_word  = ((comp << (2 * (keff - 1))) | (rc_word >> 2)) & mask;
            if (run_len < keff)
                run_len++;
            if (run_len >= keff)
            begin
                hit.canonical_kmer   = (fwd_word < rc_word) ? fwd_word : rc_word;
                hit.kmer_sequence_id = sid;
                pending_kmers.push_back(hit);
            end
        end
        // end of read clears everything, even after an emitting character
        if (last)
        begin
            fwd_word = '0;
            rc_word  = '0;
            run_len  = 0;
        end
    endtask

    task automatic add_char(input logic [NUC_W-1:0] ch, input logic last,
                            input logic [SEQ_ID_W-1:0] sid);
        feed_step_t st;
        st      = '0;
        st.kind = STEP_CHAR;
        st.nuc  = ch;
        st.last = last;
        st.sid  = sid;
        feed_q.push_back(st);
        chars_queued++;
    endtask

    task automatic add_cmd(input step_kind_e kind, input logic [K_W-1:0] kval);
        feed_step_t st;
        st      = '0;
        st.kind = kind;
        st.kval = kval;
        feed_q.push_back(st);
    endtask

    // reads of random length, mostly clean bases, some stray bytes and odd read ends
    task automatic add_random_reads(input int count, input logic [K_W-1:0] klen);
        int                  keff;
        int                  len;
        int                  n;
        logic [NUC_W-1:0]    ch;
        logic                last;
        logic [SEQ_ID_W-1:0] sid;
        keff = (klen == 0) ? 1 : (klen > MAX_K) ? MAX_K : int'(klen);
        n    = 0;
        while (n < count)
        begin
            sid = $urandom;
            if ($urandom_range(9) == 0)
                len = $urandom_range(40, 100);
            else
                len = $urandom_range(1, 2 * keff + 6);
            for (int i = 0; i < len && n < count; i++)
            begin
                if ($urandom_range(99) < 7)
                    ch = NUC_W'($urandom_range(255));
                else
                    ch = base_chars[$urandom_range(7)];
                last = ((i == len - 1) && ($urandom_range(9) != 0)) ||
                       ($urandom_range(99) == 0);
                if ($urandom_range(49) == 0)
                    sid = $urandom;
                add_char(ch, last, sid);
                n++;
            end
        end
    endtask

    // driver: feeds characters, length writes and quiet points in queue order
    always @(posedge clk)
    begin : drive_feed
        feed_step_t st;
        logic       nxt_valid;
        logic       nxt_cfg;
        int         tx_pct;
        int         tx_cyc;
        int         gap_left;
        if (rst_n)
        begin
            nxt_valid = s_tvalid;
            nxt_cfg   = cfg_valid;
            // completed transfers
            if (s_tvalid && s_tready)
            begin
                roll_kmer(s_tdata[NUC_W-1:0], s_tlast, s_tdata[IN_DATA_W-1:NUC_W]);
                chars_accepted++;
                nxt_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                kmer_len = cfg_data;
                k_writes++;
                nxt_cfg  = 1'b0;
            end
            // count quiet cycles before a length write
            if (!s_tvalid && !cfg_valid && pending_kmers.size() == 0)
                settle++;
            else
                settle = 0;
            // idle rate changes now and then, including stretches of none
            tx_cyc++;
            if (tx_cyc % 200 == 0)
                tx_pct = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 15 : 40);
            calm = (chars_queued < CALM_TAIL);
            // pick the next step once the channels are free
            if (!nxt_valid && !nxt_cfg)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (feed_q.size() > 0)
                begin
                    st = feed_q[0];
                    case (st.kind)
                        STEP_CHAR:
                        begin
                            if (!calm && $urandom_range(99) < tx_pct)
                            begin
                                gap_left = $urandom_range(9);
                            end
                            else
                            begin
                                void'(feed_q.pop_front());
                                chars_queued--;
                                s_tdata   <= {st.sid, st.nuc};
                                s_tlast   <= st.last;
                                nxt_valid = 1'b1;
                            end
                        end
                        STEP_SET_K:
                        begin
                            if (settle >= SETTLE_CYCLES)
                            begin
                                void'(feed_q.pop_front());
                                cfg_data <= st.kval;
                                nxt_cfg  = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (settle >= SETTLE_CYCLES)
                                void'(feed_q.pop_front());
                        end
                    endcase
                end
            end
            s_tvalid  <= nxt_valid;
            cfg_valid <= nxt_cfg;
        end
    end

    // monitor: checks each k-mer transfer and stalls the output in bursts
    always @(posedge clk)
    begin : watch_kmers
        out_item_t got;
        out_item_t want;
        logic      nxt_ready;
        int        rx_pct;
        int        rx_cyc;
        int        stall_left;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_kmers.size() == 0)
                begin
                    $display("%0t: unexpected k-mer %h id %h", $time,
                             got.canonical_kmer, got.kmer_sequence_id);
                    errors++;
                end
                else
                begin
                    want = pending_kmers.pop_front();
                    kmers_checked++;
                    if (got.canonical_kmer !== want.canonical_kmer)
                    begin
                        $display("%0t: canonical_kmer expected %h actual %h", $time,
                                 want.canonical_kmer, got.canonical_kmer);
                        errors++;
                    end
                    if (got.kmer_sequence_id !== want.kmer_sequence_id)
                    begin
                        $display("%0t: kmer_sequence_id expected %h actual %h", $time,
                                 want.kmer_sequence_id, got.kmer_sequence_id);
                        errors++;
                    end
                end
            end
            // output stall bursts
            rx_cyc++;
            if (rx_cyc % 200 == 100)
                rx_pct = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 15 : 40);
            nxt_ready = 1'b1;
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if (!calm && $urandom_range(99) < rx_pct)
            begin
                stall_left = $urandom_range(9);
                nxt_ready  = 1'b0;
            end
            m_tready <= nxt_ready;
        end
    end

    // stimulus, reset and end of run
    initial
    begin : main_flow
        logic [K_W-1:0] fixed_k [8];
        logic [K_W-1:0] k;
        base_chars = '{CHAR_UA, CHAR_LC, CHAR_UG, CHAR_LT,
                       CHAR_LA, CHAR_UC, CHAR_LG, CHAR_UT};
        fixed_k    = '{6'd32, 6'd63, 6'd1, 6'd33, 6'd0, 6'd2, 6'd17, 6'd31};

        // one full read at the reset length, all eight letters, last on the emitter
        for (int i = 0; i < 18; i++)
            add_char(base_chars[(i * 3) % 8], i == 17, 32'hFFFF_FFFF);
        // zero length acts as one: every base emits
        add_cmd(STEP_SET_K, 6'd0);
        add_char(base_chars[0], 1'b0, 32'h0000_0000);
        add_char(base_chars[5], 1'b0, 32'hAAAA_AAAA);
        add_char(base_chars[2], 1'b0, 32'h5555_5555);
        add_char(base_chars[7], 1'b0, 32'h0000_0001);
        // stray bytes break the run, one of them closing the read
        add_char(8'h4E, 1'b0, 32'h8000_0000);
        add_char(8'h00, 1'b1, 32'h0000_0000);
        add_char(8'hFF, 1'b0, 32'hFFFF_FFFF);

        // random phases, each under its own length; reads often span a change
        for (int p = 0; p < PHASES; p++)
        begin
            k = (p < 8) ? fixed_k[p] : 6'($urandom_range(0, 63));
            add_cmd(STEP_SET_K, k);
            if (p == 3)
            begin
                add_random_reads(PHASE_CHARS / 2, k);
                add_cmd(STEP_QUIESCE, '0);
                add_random_reads(PHASE_CHARS / 2, k);
            end
            else
            begin
                add_random_reads(PHASE_CHARS, k);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || s_tvalid || cfg_valid || pending_kmers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (pending_kmers.size() != 0)
        begin
            $display("%0t: %0d k-mers never arrived", $time, pending_kmers.size());
            errors += pending_kmers.size();
        end
        $display("run: %0d characters under %0d length writes, %0d k-mers compared",
                 chars_accepted, k_writes, kmers_checked);
        $display("run: k from 0 to 63, mixed case, stray bytes, read ends, mid-read changes");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hard limit far beyond the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
